[src/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    // Widths of the binary operand and the BCD accumulator
    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int STEP_W     = $clog2(BIN_W);
    localparam int CHAR_W     = 7;

    // Request types
    localparam logic REQ_SIGNED16   = 1'b0;
    localparam logic REQ_UNSIGNED32 = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_MINUS,
        ST_EMIT
    } state_t;

endpackage : b2da_pkg

`default_nettype wire

[src/b2da_dabble.sv]
// ----------------------------------------------------------------------------
// b2da_dabble
// One double-dabble step: add 3 to every BCD digit of 5 or more, then shift
// the BCD digits and the binary operand left by one bit as a single word.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dabble
    import b2da_pkg::*;
(
    input  wire bcd_t             bcd,
    input  wire logic [BIN_W-1:0] bin,
    output bcd_t                  bcd_shifted,
    output logic [BIN_W-1:0]      bin_shifted
);

    bcd_t             adjusted;
    logic [BCD_W-1:0] adjusted_flat;

    // Correct each digit so the shift carries into the next decade
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[i] >= DIGIT_W'(5))
                adjusted[i] = bcd[i] + DIGIT_W'(3);
            else
                adjusted[i] = bcd[i];
        end
    end

    assign adjusted_flat = adjusted;

    // Shift the operand's top bit into the lowest digit
    assign bcd_shifted = {adjusted_flat[BCD_W-2:0], bin[BIN_W-1]};
    assign bin_shifted = {bin[BIN_W-2:0], 1'b0};

endmodule : b2da_dabble

`default_nettype wire

[src/binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a signed 16-bit or unsigned 32-bit number into its decimal ASCII
// characters, most significant first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the last character has been issued. Each character appears on
// char_code for exactly one cycle with char_valid high, and last_char marks
// the final character of the number; the receiver cannot stall, so it must
// capture every character in the cycle it is shown. A number first runs
// through the steps of the shared add-3-and-shift unit, then its leading
// zero digits are skipped, and then its minus sign, if any, and its digits
// are issued through the output register. busy drops while the last
// character is shown, so the next number can be taken at the edge that
// ends it. Zero is issued as the single character '0'.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              req_type,
    input  wire logic [BIN_W-1:0]  value,
    output logic                   char_valid,
    output logic [CHAR_W-1:0]      char_code,
    output logic                   last_char
);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                neg_reg, neg_next;
    bcd_t                bcd_reg, bcd_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic                char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0]   char_code_reg, char_code_next;
    logic                last_char_reg, last_char_next;

    bcd_t                bcd_shifted;
    logic [BIN_W-1:0]    bin_shifted;
    logic [BIN_W-1:0]    magnitude;
    logic                negative;
    logic [DIGIT_W-1:0]  cur_digit;
    logic                accept;

    b2da_dabble u_dabble (
        .bcd         (bcd_reg),
        .bin         (bin_reg),
        .bcd_shifted (bcd_shifted),
        .bin_shifted (bin_shifted)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign cur_digit = bcd_reg[idx_reg];

    // Take the magnitude; 0x10000 - v covers -32768 without overflow
    always_comb
    begin
        negative  = (req_type == REQ_SIGNED16) && value[15];
        if (req_type == REQ_UNSIGNED32)
            magnitude = value;
        else if (value[15])
            magnitude = BIN_W'(17'h10000 - {1'b0, value[15:0]});
        else
            magnitude = {{(BIN_W-16){1'b0}}, value[15:0]};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_CONVERT;
            ST_CONVERT:
                if (step_reg == STEP_W'(BIN_W - 1))
                    state_next = ST_SKIP;
            ST_SKIP:
                if (cur_digit != '0 || idx_reg == '0)
                    state_next = neg_reg ? ST_MINUS : ST_EMIT;
            ST_MINUS:
                state_next = ST_EMIT;
            ST_EMIT:
                if (idx_reg == '0)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and character outputs
    always_comb
    begin
        step_next       = step_reg;
        idx_next        = idx_reg;
        neg_next        = neg_reg;
        bcd_next        = bcd_reg;
        bin_next        = bin_reg;
        char_valid_next = 1'b0;
        char_code_next  = char_code_reg;
        last_char_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    bin_next  = magnitude;
                    bcd_next  = '0;
                    neg_next  = negative;
                    step_next = '0;
                    idx_next  = IDX_W'(NUM_DIGITS - 1);
                end
            ST_CONVERT:
            begin
                bcd_next  = bcd_shifted;
                bin_next  = bin_shifted;
                step_next = step_reg + STEP_W'(1);
            end
            ST_SKIP:
                // Drop leading zero digits, keeping at least the lowest one
                if (cur_digit == '0 && idx_reg != '0)
                    idx_next = idx_reg - IDX_W'(1);
            ST_MINUS:
            begin
                char_valid_next = 1'b1;
                char_code_next  = CHAR_MINUS;
            end
            ST_EMIT:
            begin
                char_valid_next = 1'b1;
                char_code_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
                last_char_next  = (idx_reg == '0);
                if (idx_reg != '0)
                    idx_next = idx_reg - IDX_W'(1);
            end
            default:
            begin
                char_valid_next = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        idx_reg       <= idx_next;
        neg_reg       <= neg_next;
        bcd_reg       <= bcd_next;
        bin_reg       <= bin_next;
        char_code_reg <= char_code_next;
        last_char_reg <= last_char_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign last_char  = last_char_reg;

endmodule : binary_to_decimal_ascii

`default_nettype wire

[test/binary_to_decimal_ascii_test.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_test
// Self-checking bench for the decimal ASCII converter. Numbers are issued
// through the start/busy handshake, and each character the block prints is
// checked against a predicted character stream. Stimulus starts with
// directed corner values and then moves to random numbers under several
// sender idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_test
    import b2da_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIX        = 10;
    localparam int RANDOM_ITEMS = 159;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    // Predict the characters of each accepted number and check them in order
    class ascii_scoreboard;
        ascii_char_t pending_chars[$];
        int          errors;
        int          numbers;
        int          chars;

        function new();
            errors  = 0;
            numbers = 0;
            chars   = 0;
        endfunction

        // Expand one accepted number into its expected characters
        function void note_number(logic req, logic [BIN_W-1:0] val);
            logic [BIN_W-1:0] magnitude;
            logic [3:0]       digit_buf [NUM_DIGITS];
            int               count;
            bit               negative;
            negative = 1'b0;
            if (req == REQ_SIGNED16)
            begin
                negative  = val[15];
                magnitude = negative ? (32'h0001_0000 - {16'h0000, val[15:0]})
                                     : {16'h0000, val[15:0]};
            end
            else
            begin
                magnitude = val;
            end
            count = 0;
            do
            begin
                digit_buf[count] = 4'(magnitude % RADIX);
                magnitude        = magnitude / RADIX;
                count++;
            end
            while (magnitude != 0 && count < NUM_DIGITS);
            if (negative)
                pending_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
            for (int i = count - 1; i >= 0; i--)
                pending_chars.push_back('{code: CHAR_ZERO + 7'(digit_buf[i]),
                                          last: (i == 0)});
            numbers++;
        endfunction

        // Compare one printed character with the oldest expected one
        function void check_char(logic [CHAR_W-1:0] code, logic last);
            ascii_char_t want;
            chars++;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: char_code=%h last_char=%b", code, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $error("char_code: expected %h, got %h", want.code, code);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_char: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              req_type   = 1'b0;
    logic [BIN_W-1:0]  value      = '0;
    logic              busy;
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    ascii_scoreboard   sb = new();

    binary_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .value      (value),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    // Generate a 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Capture every character in the cycle it is shown
    always @(posedge clk)
    begin
        if (rst_n && char_valid)
            sb.check_char(char_code, last_char);
    end

    // Hold one transaction until the block takes it; leave start high
    task automatic send_number(input logic req, input logic [BIN_W-1:0] val);
        start    <= 1'b1;
        req_type <= req;
        value    <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_number(req, val);
    endtask

    // Drop start for a random gap
    task automatic idle_sender(input int max_gap);
        start <= 1'b0;
        repeat ($urandom_range(1, max_gap))
            @(posedge clk);
    endtask

    // Drop start and wait until every expected character has arrived
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Pick a number with a spread of digit counts and sign cases
    task automatic random_number(output logic req, output logic [BIN_W-1:0] val);
        int pick;
        pick = $urandom_range(0, 9);
        req  = 1'($urandom);
        case (pick)
            0, 1, 2: val = $urandom;
            3:       val = {16'($urandom), 16'(16'h8000 + $urandom_range(0, 3))};
            4:       val = {16'($urandom), 16'(16'hFFFF - $urandom_range(0, 3))};
            5:       val = $urandom_range(0, 12);
            default: val = $urandom >> $urandom_range(0, 31);
        endcase
    endtask

    // Limit the run
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int               idle_pct [3];
        logic             req;
        logic [BIN_W-1:0] val;
        idle_pct = '{0, 74, 17};

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: signed extremes, ignored upper bits, digit rollovers
        send_number(REQ_SIGNED16,   32'h0000_0000);
        send_number(REQ_SIGNED16,   32'h0000_0001);
        send_number(REQ_SIGNED16,   32'h0000_FFFF);
        send_number(REQ_SIGNED16,   32'h0000_7FFF);
        send_number(REQ_SIGNED16,   32'h0000_8000);
        send_number(REQ_SIGNED16,   32'hFFFF_8001);
        send_number(REQ_SIGNED16,   32'hFFFF_0005);
        send_number(REQ_SIGNED16,   32'hABCD_0000);
        send_number(REQ_SIGNED16,   32'h0000_FFF6);
        send_number(REQ_SIGNED16,   32'h0000_0009);
        send_number(REQ_SIGNED16,   32'h0000_000A);
        send_number(REQ_UNSIGNED32, 32'h0000_0000);
        send_number(REQ_UNSIGNED32, 32'h0000_0001);
        send_number(REQ_UNSIGNED32, 32'd9);
        send_number(REQ_UNSIGNED32, 32'd10);
        send_number(REQ_UNSIGNED32, 32'd99999);
        send_number(REQ_UNSIGNED32, 32'd100000);
        send_number(REQ_UNSIGNED32, 32'd999999999);
        send_number(REQ_UNSIGNED32, 32'd1000000000);
        send_number(REQ_UNSIGNED32, 32'h8000_0000);
        send_number(REQ_UNSIGNED32, 32'd4000000000);
        send_number(REQ_UNSIGNED32, 32'hFFFF_FFFF);
        wait_for_drain();

        // Random numbers under each sender idle mix
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if ($urandom_range(1, 100) <= idle_pct[phase])
                    idle_sender($urandom_range(0, 3) == 0 ? 60 : 8);
                random_number(req, val);
                send_number(req, val);
            end
            wait_for_drain();
        end

        // Let any stray character show up
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Checked %0d numbers (%0d characters) under idle mixes of 0, 74 and 17 pct",
                 sb.numbers, sb.chars);
        $display("Directed set covered zero, signed extremes and full 32-bit range");
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : binary_to_decimal_ascii_test

`default_nettype wire
